/* design/pscc_pkg.sv */
// Shared types and constants for the clamped PID speed controller.
// Holds the beat payload structs, the configuration register set and its indexes.
// No dependencies.
package pscc_pkg;

  // Field widths fixed by the interface.
  localparam int unsigned SPEED_W = 10;
  localparam int unsigned COEFF_W = 12;
  localparam int unsigned DRIVE_W = 8;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 12;

  // Register reset values.
  localparam logic [DRIVE_W-1:0] MIN_DRIVE_RST = 8'd0;
  localparam logic [DRIVE_W-1:0] MAX_DRIVE_RST = 8'd255;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KP_COEFF  = 3'd0,
    REG_KI_COEFF  = 3'd1,
    REG_KD_COEFF  = 3'd2,
    REG_MIN_DRIVE = 3'd3,
    REG_MAX_DRIVE = 3'd4
  } cfg_idx_t;

  // One input beat.
  typedef struct packed {
    logic [SPEED_W-1:0] set_point;
    logic [SPEED_W-1:0] feedback;
  } in_item_t;

  // One result beat.
  typedef struct packed {
    logic [DRIVE_W-1:0] drive;
    logic               saturated;
  } out_item_t;

  // Current register contents.
  typedef struct packed {
    logic [COEFF_W-1:0] kp_coeff;
    logic [COEFF_W-1:0] ki_coeff;
    logic [COEFF_W-1:0] kd_coeff;
    logic [DRIVE_W-1:0] min_drive;
    logic [DRIVE_W-1:0] max_drive;
  } cfg_t;

endpackage

/* design/pscc_cfg_regs.sv */
// Configuration register file of the clamped PID speed controller.
// Depends on pscc_pkg for the register indexes and the cfg_t struct.
module pscc_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [pscc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pscc_pkg::CFG_DATA_W-1:0] cfg_data,
  output pscc_pkg::cfg_t                 cfg
);
  import pscc_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // Writes are always taken; an index beyond the list is ignored.
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        REG_KP_COEFF:  cfg_nxt.kp_coeff  = cfg_data;
        REG_KI_COEFF:  cfg_nxt.ki_coeff  = cfg_data;
        REG_KD_COEFF:  cfg_nxt.kd_coeff  = cfg_data;
        REG_MIN_DRIVE: cfg_nxt.min_drive = cfg_data[DRIVE_W-1:0];
        REG_MAX_DRIVE: cfg_nxt.max_drive = cfg_data[DRIVE_W-1:0];
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.kp_coeff  <= '0;
      cfg_r.ki_coeff  <= '0;
      cfg_r.kd_coeff  <= '0;
      cfg_r.min_drive <= MIN_DRIVE_RST;
      cfg_r.max_drive <= MAX_DRIVE_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

/* design/pscc_core.sv */
// Arithmetic of the clamped PID speed controller: error, clamped integral,
// derivative term, weighted sum, truncating shift and output clamp.
// Depends on pscc_pkg for the payload and register structs.
module pscc_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  pscc_pkg::in_item_t  item,
  input  pscc_pkg::cfg_t      cfg,
  output pscc_pkg::out_item_t result
);
  import pscc_pkg::*;

  localparam int unsigned ERR_W  = SPEED_W + 1;
  localparam int unsigned DLT_W  = ERR_W + 1;
  localparam int unsigned IACC_W = ERR_W + 1;
  localparam int unsigned PP_W   = COEFF_W + 1 + ERR_W;
  localparam int unsigned PI_W   = COEFF_W + 1 + DRIVE_W + 1;
  localparam int unsigned PD_W   = COEFF_W + 1 + DLT_W;
  localparam int unsigned ACC_W  = PD_W + 2;
  localparam int unsigned Q_SH   = 8;
  localparam int unsigned RAW_W  = ACC_W - Q_SH;

  typedef struct packed {
    logic [DRIVE_W-1:0] value;
    logic               hit;
  } clamp_t;

  // Clamp to the drive limits; the upper limit is checked first.
  function automatic clamp_t clamp_drive(input logic signed [RAW_W-1:0] v,
                                         input logic [DRIVE_W-1:0] lo,
                                         input logic [DRIVE_W-1:0] hi);
    clamp_t c;
    logic signed [RAW_W-1:0] hi_s;
    logic signed [RAW_W-1:0] lo_s;
    hi_s = $signed({{(RAW_W-DRIVE_W){1'b0}}, hi});
    lo_s = $signed({{(RAW_W-DRIVE_W){1'b0}}, lo});
    if (v >= hi_s) begin
      c.value = hi;
      c.hit   = (v > hi_s);
    end else if (v <= lo_s) begin
      c.value = lo;
      c.hit   = (v < lo_s);
    end else begin
      c.value = v[DRIVE_W-1:0];
      c.hit   = 1'b0;
    end
    return c;
  endfunction

  logic [DRIVE_W-1:0]      integral_r;
  logic signed [ERR_W-1:0] prev_err_r;

  logic signed [ERR_W-1:0]   err;
  logic signed [DLT_W-1:0]   delta;
  logic signed [IACC_W-1:0]  int_acc;
  clamp_t                    int_clamp;
  logic signed [COEFF_W:0]   kp_s;
  logic signed [COEFF_W:0]   ki_s;
  logic signed [COEFF_W:0]   kd_s;
  logic signed [DRIVE_W:0]   int_s;
  logic signed [PP_W-1:0]    prod_p;
  logic signed [PI_W-1:0]    prod_i;
  logic signed [PD_W-1:0]    prod_d;
  logic signed [ACC_W-1:0]   acc;
  logic                      round_up;
  logic signed [RAW_W-1:0]   raw;
  clamp_t                    drv_clamp;

  // Error and its change since the previous sample.
  assign err   = $signed({1'b0, item.set_point}) - $signed({1'b0, item.feedback});
  assign delta = $signed({err[ERR_W-1], err}) - $signed({prev_err_r[ERR_W-1], prev_err_r});

  // Running integral, held within the drive limits.
  assign int_acc   = $signed({{(IACC_W-DRIVE_W){1'b0}}, integral_r})
                   + $signed({err[ERR_W-1], err});
  assign int_clamp = clamp_drive($signed({{(RAW_W-IACC_W){int_acc[IACC_W-1]}}, int_acc}),
                                 cfg.min_drive, cfg.max_drive);

  // The three gain products, all exact.
  assign kp_s   = $signed({1'b0, cfg.kp_coeff});
  assign ki_s   = $signed({1'b0, cfg.ki_coeff});
  assign kd_s   = $signed({1'b0, cfg.kd_coeff});
  assign int_s  = $signed({1'b0, int_clamp.value});
  assign prod_p = kp_s * err;
  assign prod_i = ki_s * int_s;
  assign prod_d = kd_s * delta;

  assign acc = $signed({{(ACC_W-PP_W){prod_p[PP_W-1]}}, prod_p})
             + $signed({{(ACC_W-PI_W){prod_i[PI_W-1]}}, prod_i})
             + $signed({{(ACC_W-PD_W){prod_d[PD_W-1]}}, prod_d});

  // Drop the Q8 fraction, rounding toward zero for a negative sum.
  assign round_up  = acc[ACC_W-1] & (|acc[Q_SH-1:0]);
  assign raw       = $signed(acc[ACC_W-1:Q_SH]) + $signed({{(RAW_W-1){1'b0}}, round_up});
  assign drv_clamp = clamp_drive(raw, cfg.min_drive, cfg.max_drive);

  assign result.drive     = drv_clamp.value;
  assign result.saturated = drv_clamp.hit;

  // Loop state moves on once per sample passed to the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integral_r <= '0;
      prev_err_r <= '0;
    end else if (step) begin
      integral_r <= int_clamp.value;
      prev_err_r <= err;
    end
  end

endmodule

/* design/pid_speed_controller_clamped_top.sv */
// Clamped PID speed controller: top level with the input and result registers.
// Depends on pscc_pkg, pscc_cfg_regs and pscc_core.
//
// Use: each input beat on in_data carries one sample (set point and averaged
// speed feedback); each result beat on out_data carries the drive command and
// a flag that is set when the drive was clamped beyond a limit.
// Both channels use valid and stall; a beat moves on an edge with valid high
// and stall low. The configuration port takes a register index and data on
// any edge with cfg_valid high (cfg_ready is always high); registers should
// be written only while no sample is in flight.
// A sample accepted into the input register is passed through the core into
// the result register, and so onto out_data, once that register is free or
// being emptied. Throughput: one sample per cycle while out_stall is low; the
// whole PID step is one pass of logic from the input register to the result
// register, including the update of the integral and the stored error.
// When the receiver stalls, the result waits in the output register while
// one more sample may still be taken into the input register; then in_stall
// rises until the result is taken.
// Reset clears the integral, the stored error, both valid flags, the gains
// and the lower limit, and sets the upper limit to 255.
module pid_speed_controller_clamped_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  pscc_pkg::in_item_t             in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output pscc_pkg::out_item_t            out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [pscc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pscc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import pscc_pkg::*;

  cfg_t      cfg;
  out_item_t result;

  logic      in_vld_r;
  logic      in_vld_nxt;
  in_item_t  in_data_r;
  logic      out_vld_r;
  logic      out_vld_nxt;
  out_item_t out_data_r;
  logic      advance;

  pscc_cfg_regs u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  pscc_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (advance),
    .item   (in_data_r),
    .cfg    (cfg),
    .result (result)
  );

  // A held sample moves on when the result register is free or being emptied.
  assign advance  = in_vld_r & (~out_vld_r | ~out_stall);
  assign in_stall = in_vld_r & ~advance;

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_valid && !in_stall) begin
      in_vld_nxt = 1'b1;
    end else if (advance) begin
      in_vld_nxt = 1'b0;
    end
  end

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (advance) begin
      out_vld_nxt = 1'b1;
    end else if (!out_stall) begin
      out_vld_nxt = 1'b0;
    end
  end

  // Valid flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_data_r <= in_data;
    end
    if (advance) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

endmodule

/* bench/pscc_checker.sv */
`timescale 1ns / 1ps
// Checker for the clamped PID speed controller: watches the sample, result and register channels.
// It predicts each drive command and compares it with the result beats.
// Depends on pscc_pkg.
module pscc_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  pscc_pkg::in_item_t              in_data,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  pscc_pkg::out_item_t             out_data,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [pscc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pscc_pkg::CFG_DATA_W-1:0] cfg_data,
  output int unsigned                     errors,
  output int unsigned                     outstanding
);
  import pscc_pkg::*;

  localparam int Q_SHIFT = 8;
  localparam int unsigned PRINT_CAP = 100;

  // Shadow copy of the registers and of the loop state.
  cfg_t                gains;
  logic [DRIVE_W-1:0]  integ;
  logic signed [SPEED_W:0] last_err;
  out_item_t           drive_expected_q[$];
  int unsigned         fail_tally = 0;
  int unsigned         result_beats = 0;

  // Clamp to the drive limits; the upper limit is tested first, so crossed
  // limits give max_drive for anything at or above it and min_drive otherwise.
  function automatic longint clamp_to_limits(input longint v, output logic hit);
    longint hi;
    longint lo;
    hi = longint'(gains.max_drive);
    lo = longint'(gains.min_drive);
    hit = 1'b0;
    if (v >= hi) begin
      hit = (v > hi);
      return hi;
    end
    if (v <= lo) begin
      hit = (v < lo);
      return lo;
    end
    return v;
  endfunction

  // One controller step: updates the integral and the stored error and
  // returns the drive command expected for this sample.
  function automatic out_item_t advance_loop(input in_item_t s);
    longint    err;
    longint    delta;
    longint    acc;
    longint    raw;
    logic      hit;
    out_item_t r;
    err = longint'(s.set_point) - longint'(s.feedback);
    delta = err - longint'(last_err);
    acc = clamp_to_limits(longint'(integ) + err, hit);
    integ = acc[DRIVE_W-1:0];
    acc = longint'(gains.kp_coeff) * err
        + longint'(gains.ki_coeff) * longint'(integ)
        + longint'(gains.kd_coeff) * delta;
    // Division by 256 truncates toward zero, also for a negative sum.
    if (acc < 0) begin
      raw = -((-acc) >>> Q_SHIFT);
    end else begin
      raw = acc >>> Q_SHIFT;
    end
    raw = clamp_to_limits(raw, hit);
    last_err = err[SPEED_W:0];
    r.drive = raw[DRIVE_W-1:0];
    r.saturated = hit;
    return r;
  endfunction

  // Prints one line per mismatch (up to a cap) and counts every one.
  task automatic report_mismatch(input string what, input int unsigned beat,
                                 input longint got, input longint want_v);
    fail_tally++;
    if (fail_tally <= PRINT_CAP) begin
      $display("%0t pscc_checker: result beat %0d, %s: got %0d, expected %0d",
               $time, beat, what, got, want_v);
    end
  endtask

  // All channels are sampled at the rising edge, before the bench drives
  // its next values.
  always @(posedge clk) begin : watch
    out_item_t want;
    if (!rst_n) begin
      gains.kp_coeff  = '0;
      gains.ki_coeff  = '0;
      gains.kd_coeff  = '0;
      gains.min_drive = MIN_DRIVE_RST;
      gains.max_drive = MAX_DRIVE_RST;
      integ = '0;
      last_err = '0;
      drive_expected_q.delete();
    end else begin
      // Register writes; indexes beyond the list are ignored.
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_KP_COEFF:  gains.kp_coeff  = cfg_data[COEFF_W-1:0];
          REG_KI_COEFF:  gains.ki_coeff  = cfg_data[COEFF_W-1:0];
          REG_KD_COEFF:  gains.kd_coeff  = cfg_data[COEFF_W-1:0];
          REG_MIN_DRIVE: gains.min_drive = cfg_data[DRIVE_W-1:0];
          REG_MAX_DRIVE: gains.max_drive = cfg_data[DRIVE_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        drive_expected_q.push_back(advance_loop(in_data));
      end
      // Each result beat is matched against the oldest prediction.
      if (out_valid && !out_stall) begin
        if (drive_expected_q.size() == 0) begin
          report_mismatch("result with nothing expected", result_beats,
                          longint'(out_data.drive), 0);
        end else begin
          want = drive_expected_q.pop_front();
          if (out_data.drive !== want.drive) begin
            report_mismatch("drive", result_beats, longint'(out_data.drive),
                            longint'(want.drive));
          end
          if (out_data.saturated !== want.saturated) begin
            report_mismatch("saturated", result_beats, longint'(out_data.saturated),
                            longint'(want.saturated));
          end
        end
        result_beats++;
      end
    end
    errors <= fail_tally;
    outstanding <= drive_expected_q.size();
  end

endmodule

/* bench/pid_speed_controller_clamped_top_tb.sv */
`timescale 1ns / 1ps
// Bench top for the clamped PID speed controller: clock, reset, sample and register stimulus.
// Depends on pscc_pkg, pid_speed_controller_clamped_top and pscc_checker.
module pid_speed_controller_clamped_top_tb;
  import pscc_pkg::*;

  localparam int PHASE_BEATS  = 150;
  localparam int FINAL_BEATS  = 200;
  localparam int RAND_PHASES  = 11;
  localparam int HOLD_CYCLES  = 80;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_stall;
  out_item_t             out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int unsigned fail_count;
  int unsigned results_pending;
  bit          quiet_run = 1'b0;
  bit          hold_request = 1'b0;
  bit          sender_gaps = 1'b1;
  int          track_point = 512;

  pid_speed_controller_clamped_top u_dut (
    .clk, .rst_n,
    .in_valid, .in_stall, .in_data,
    .out_valid, .out_stall, .out_data,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  pscc_checker u_checker (
    .clk, .rst_n,
    .in_valid, .in_stall, .in_data,
    .out_valid, .out_stall, .out_data,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .errors(fail_count),
    .outstanding(results_pending)
  );

  // 50 MHz clock.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Run limit, far beyond the slowest correct run.
  initial begin
    #20ms;
    $display("pid_speed_controller_clamped_top: mismatch");
    $finish;
  end

  // Result side: random stall bursts in stretches, one long hold-off on request,
  // and none at all in the final part of the run.
  initial begin : receiver
    int burst;
    bit stall_bursts;
    int tick;
    stall_bursts = 1'b1;
    tick = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      tick++;
      if (tick % 200 == 0) begin
        stall_bursts = ($urandom_range(0, 3) != 0);
      end
      if (hold_request) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
        hold_request = 1'b0;
      end else if (!quiet_run && stall_bursts && $urandom_range(0, 4) == 0) begin
        burst = $urandom_range(1, 17);
        out_stall <= 1'b1;
        repeat (burst) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // One register write; the caller lowers cfg_valid after the last one.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Writes the whole register set; the limits carry junk in the unused upper bits.
  task automatic load_settings(input cfg_t s);
    write_reg(REG_KP_COEFF, s.kp_coeff);
    write_reg(REG_KI_COEFF, s.ki_coeff);
    write_reg(REG_KD_COEFF, s.kd_coeff);
    write_reg(REG_MIN_DRIVE, {4'($urandom), s.min_drive});
    write_reg(REG_MAX_DRIVE, {4'($urandom), s.max_drive});
    cfg_valid <= 1'b0;
  endtask

  // Offers one sample beat and waits until it is taken.
  task automatic send_sample(input in_item_t s);
    in_valid <= 1'b1;
    in_data  <= s;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_pair(input int sp, input int fb);
    in_item_t s;
    s.set_point = SPEED_W'(sp);
    s.feedback  = SPEED_W'(fb);
    send_sample(s);
  endtask

  // Random gap between beats on the sample side.
  task automatic sender_idle();
    if (!quiet_run && sender_gaps && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
  endtask

  // Waits until every predicted result has been taken.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [COEFF_W-1:0] pick_gain();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return '1;
      2:       return COEFF_W'($urandom_range(0, 4095));
      default: return COEFF_W'($urandom_range(0, 400));
    endcase
  endfunction

  // Random register set: wide, narrow, equal and crossed limits.
  function automatic cfg_t pick_settings();
    cfg_t s;
    int a;
    int b;
    s.kp_coeff = pick_gain();
    s.ki_coeff = pick_gain();
    s.kd_coeff = pick_gain();
    a = $urandom_range(0, 255);
    b = $urandom_range(0, 255);
    case ($urandom_range(0, 5))
      0: begin
        s.min_drive = '0;
        s.max_drive = '1;
      end
      1: begin
        s.min_drive = DRIVE_W'(a);
        s.max_drive = DRIVE_W'(a);
      end
      2: begin
        s.min_drive = DRIVE_W'($urandom_range(128, 255));
        s.max_drive = DRIVE_W'($urandom_range(0, 127));
      end
      default: begin
        s.min_drive = DRIVE_W'((a < b) ? a : b);
        s.max_drive = DRIVE_W'((a < b) ? b : a);
      end
    endcase
    return s;
  endfunction

  // Mostly a loop that tracks a set point with feedback close to it; the rest
  // is full-range noise and extreme values.
  function automatic in_item_t make_sample();
    in_item_t s;
    int sp;
    int fb;
    case ($urandom_range(0, 5))
      0: begin
        sp = $urandom_range(0, 1023);
        fb = $urandom_range(0, 1023);
      end
      1: begin
        sp = ($urandom_range(0, 1) != 0) ? 1023 : $urandom_range(0, 1023);
        fb = ($urandom_range(0, 1) != 0) ? 0 : 1023;
      end
      default: begin
        if ($urandom_range(0, 15) == 0) begin
          track_point = $urandom_range(0, 1023);
        end
        sp = track_point;
        fb = sp + int'($urandom_range(0, 80)) - 40;
        if (fb < 0) fb = 0;
        if (fb > 1023) fb = 1023;
      end
    endcase
    s.set_point = SPEED_W'(sp);
    s.feedback  = SPEED_W'(fb);
    return s;
  endfunction

  // Stimulus: reset, directed cases, random phases with fresh settings, verdict.
  initial begin : stimulus
    cfg_t s;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset values: zero gains give the lower limit with no saturation.
    send_pair(1023, 0);
    send_pair(0, 1023);
    drain();

    // Writes to indexes beyond the list must leave the registers alone.
    for (int i = int'(REG_MAX_DRIVE) + 1; i < (1 << CFG_IDX_W); i++) begin
      write_reg(CFG_IDX_W'(i), CFG_DATA_W'($urandom));
    end

    // Unity proportional gain: drive equal to a limit is not saturated,
    // one step beyond it is.
    s = '{kp_coeff: 12'd256, ki_coeff: 12'd0, kd_coeff: 12'd0,
          min_drive: 8'd0, max_drive: 8'd255};
    load_settings(s);
    send_pair(255, 0);
    send_pair(0, 0);
    send_pair(256, 0);
    send_pair(0, 1);
    drain();

    // Smallest gain: a negative sum truncates toward zero, not down.
    s.kp_coeff = 12'd1;
    load_settings(s);
    send_pair(0, 255);
    send_pair(0, 256);
    send_pair(1023, 0);
    drain();

    // Largest gains: the integral runs into both limits and the products peak.
    s = '{kp_coeff: '1, ki_coeff: '1, kd_coeff: '1, min_drive: 8'd0, max_drive: 8'd255};
    load_settings(s);
    send_pair(1023, 0);
    send_pair(1023, 0);
    send_pair(0, 1023);
    send_pair(0, 1023);
    send_pair(1023, 1023);
    send_pair(0, 0);
    send_pair(10'h2AA, 10'h155);
    send_pair(10'h155, 10'h2AA);
    drain();

    // Crossed limits: lower limit above the upper one.
    s = '{kp_coeff: 12'd300, ki_coeff: 12'd40, kd_coeff: 12'd100,
          min_drive: 8'd200, max_drive: 8'd50};
    load_settings(s);
    send_pair(600, 500);
    send_pair(500, 600);
    send_pair(512, 512);
    send_pair(1023, 0);
    drain();

    // Random phases, each under its own register set.
    for (int phase = 0; phase <= RAND_PHASES; phase++) begin
      if (phase == 0) begin
        s = '{kp_coeff: '1, ki_coeff: '1, kd_coeff: '1, min_drive: '0, max_drive: '1};
      end else if (phase == 1) begin
        s = '{kp_coeff: '0, ki_coeff: '0, kd_coeff: '0, min_drive: '1, max_drive: '0};
      end else begin
        s = pick_settings();
      end
      load_settings(s);
      if (phase == RAND_PHASES) begin
        quiet_run = 1'b1;
      end
      // Long hold-off on the result side while beats keep coming.
      if (phase == 3) begin
        hold_request = 1'b1;
      end
      for (int n = 0; n < ((phase == RAND_PHASES) ? FINAL_BEATS : PHASE_BEATS); n++) begin
        if (n % 40 == 0) begin
          sender_gaps = ($urandom_range(0, 3) != 0);
        end
        if (!(phase == 3 && n < 20)) begin
          sender_idle();
        end
        send_sample(make_sample());
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("pid_speed_controller_clamped_top: match");
    end else begin
      $display("pid_speed_controller_clamped_top: mismatch");
    end
    $finish;
  end

endmodule
